FILE: rtl/srm_pkg.sv
// Shared types, constants and opcode helpers for the six-register machine step block.
`default_nettype none

package srm_pkg;

  localparam int NumRegs   = 6;
  localparam int DataWidth = 64;
  localparam int HalfW     = DataWidth / 2;
  localparam int HiW       = DataWidth - HalfW;
  localparam int IdxW      = 3;
  localparam int ModeW     = 4;
  localparam int OperandW  = 32;
  localparam int PlenW     = 16;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 16;

  typedef logic [DataWidth-1:0] word_t;
  typedef word_t rf_t [NumRegs];

  typedef enum logic [ModeW-1:0] {
    OpAddr = 4'd0,
    OpAddi = 4'd1,
    OpMulr = 4'd2,
    OpMuli = 4'd3,
    OpBanr = 4'd4,
    OpBani = 4'd5,
    OpBorr = 4'd6,
    OpBori = 4'd7,
    OpSetr = 4'd8,
    OpSeti = 4'd9,
    OpGtir = 4'd10,
    OpGtri = 4'd11,
    OpGtrr = 4'd12,
    OpEqir = 4'd13,
    OpEqri = 4'd14,
    OpEqrr = 4'd15
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgIpBinding     = 1'b0,
    CfgProgramLength = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    word_t next_pc;
    word_t written_value;
    logic  halted;
    logic  bad_index;
  } result_t;

  function automatic logic op_a_is_reg(op_e op);
    logic r;
    case (op)
      OpSeti, OpGtir, OpEqir: r = 1'b0;
      default:                r = 1'b1;
    endcase
    return r;
  endfunction

  function automatic logic op_b_is_reg(op_e op);
    logic r;
    case (op)
      OpAddr, OpMulr, OpBanr, OpBorr, OpGtrr, OpEqrr, OpGtir, OpEqir: r = 1'b1;
      default:                                                       r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic word_t read_reg(rf_t rf, logic [IdxW-1:0] idx);
    word_t v;
    v = '0;
    for (int i = 0; i < NumRegs; i++) begin
      if (idx == IdxW'(i)) begin
        v = rf[i];
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/srm_in_if.sv
// Instruction channel carrying one opcode with its operands and destination.
`default_nettype none

interface srm_in_if;
  logic                             valid;
  logic                             ready;
  logic [srm_pkg::ModeW-1:0]        mode;
  logic [srm_pkg::OperandW-1:0]     operand_a;
  logic [srm_pkg::OperandW-1:0]     operand_b;
  logic [srm_pkg::IdxW-1:0]         dest_reg;

  modport source (output valid, mode, operand_a, operand_b, dest_reg, input ready);
  modport sink (input valid, mode, operand_a, operand_b, dest_reg, output ready);
endinterface

`default_nettype wire

FILE: rtl/srm_out_if.sv
// Result channel carrying the next pc, the written value and the status flags.
`default_nettype none

interface srm_out_if;
  logic                          valid;
  logic                          ready;
  logic [srm_pkg::DataWidth-1:0] next_pc;
  logic [srm_pkg::DataWidth-1:0] written_value;
  logic                          halted;
  logic                          bad_index;

  modport source (output valid, next_pc, written_value, halted, bad_index, input ready);
  modport sink (input valid, next_pc, written_value, halted, bad_index, output ready);
endinterface

`default_nettype wire

FILE: rtl/srm_cfg_if.sv
// Configuration write channel carrying a register index and write data.
`default_nettype none

interface srm_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [srm_pkg::CfgIdxW-1:0]  index;
  logic [srm_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/six_register_machine_step.sv
// Top level of the six-register machine: register file, pc, execute logic and result queue.
//
// Usage: each transaction on in_i is one instruction (mode, operand_a, operand_b,
// dest_reg). If ip_binding selects one of the six registers, the block copies its pc into it,
// executes the instruction against its register file and returns one transaction
// on out_o with the next pc, the written value, a halt flag and a bad-index flag.
// Configuration is written through cfg_i: index 0 is ip_binding, index 1 is
// program_length. cfg_i is always ready and must only be used while the block
// is idle.
// Execution and throughput: a non-multiply instruction is executed in the cycle it
// is accepted and its result is registered into the result queue before it appears
// on out_o; one such instruction is taken per cycle while the queue has room and
// no multiply is busy. mulr and muli with valid indexes build the 64-bit product
// from registered 32-bit partial products and hold in_i.ready low for one cycle.
// Reset clears the register file, the pc and the result queue and sets
// ip_binding to 0 and program_length to 1.
// A two-entry result queue holds results while the receiver stalls; when both
// entries are full, in_i.ready drops and rises again the cycle after one is taken.
`default_nettype none

module six_register_machine_step (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  srm_cfg_if.sink    cfg_i,
  srm_in_if.sink     in_i,
  srm_out_if.source  out_o
);
  import srm_pkg::*;

  rf_t                 rf_q;
  word_t               pc_q;
  logic [IdxW-1:0]     ip_q;
  logic [PlenW-1:0]    plen_q;

  logic                busy_q;
  logic [IdxW-1:0]     mul_dest_q;
  logic [2*HalfW-1:0]  p0_q;
  logic [HiW-1:0]      p1_q;
  logic [HiW-1:0]      p2_q;

  result_t             fifo_q [2];
  logic                wr_ptr_q;
  logic                rd_ptr_q;
  logic [1:0]          count_q;

  op_e                 op;
  logic                bound;
  rf_t                 rf_eff;
  word_t               va;
  word_t               vb;
  word_t               res;
  logic                bad;
  logic                is_mul;
  logic                in_fire;
  logic                start_mul;
  logic                commit;
  rf_t                 rf_base;
  rf_t                 rf_d;
  logic                wr_en;
  logic [IdxW-1:0]     wr_idx;
  word_t               wr_val;
  word_t               prod;
  word_t               npc;
  result_t             res_d;
  logic                pop;

  assign op       = op_e'(in_i.mode);
  assign bound    = 32'(ip_q) < 32'(NumRegs);
  assign in_i.ready = !busy_q && (count_q != 2'd2);
  assign in_fire  = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    for (int i = 0; i < NumRegs; i++) begin
      rf_eff[i] = (bound && ip_q == IdxW'(i)) ? pc_q : rf_q[i];
    end
  end

  always_comb begin
    bad = 1'b0;
    if (op_a_is_reg(op)) begin
      va = read_reg(rf_eff, in_i.operand_a[IdxW-1:0]);
      if (in_i.operand_a >= OperandW'(NumRegs)) begin
        bad = 1'b1;
      end
    end else begin
      va = DataWidth'(in_i.operand_a);
    end
    if (op_b_is_reg(op)) begin
      vb = read_reg(rf_eff, in_i.operand_b[IdxW-1:0]);
      if (in_i.operand_b >= OperandW'(NumRegs)) begin
        bad = 1'b1;
      end
    end else begin
      vb = DataWidth'(in_i.operand_b);
    end
    if (32'(in_i.dest_reg) >= 32'(NumRegs)) begin
      bad = 1'b1;
    end
  end

  always_comb begin
    case (op)
      OpAddr, OpAddi:         res = va + vb;
      OpBanr, OpBani:         res = va & vb;
      OpBorr, OpBori:         res = va | vb;
      OpSetr, OpSeti:         res = va;
      OpGtir, OpGtri, OpGtrr: res = (va > vb) ? DataWidth'(1) : '0;
      OpEqir, OpEqri, OpEqrr: res = (va == vb) ? DataWidth'(1) : '0;
      default:                res = '0;
    endcase
    if (bad) begin
      res = '0;
    end
  end

  assign is_mul    = (op == OpMulr) || (op == OpMuli);
  assign start_mul = in_fire && is_mul && !bad;
  assign prod      = DataWidth'(p0_q) + {HiW'(p1_q + p2_q), {HalfW{1'b0}}};

  always_comb begin
    if (busy_q) begin
      rf_base = rf_q;
      wr_en   = 1'b1;
      wr_idx  = mul_dest_q;
      wr_val  = prod;
      commit  = 1'b1;
      res_d.bad_index = 1'b0;
    end else begin
      rf_base = rf_eff;
      wr_en   = !bad;
      wr_idx  = in_i.dest_reg;
      wr_val  = res;
      commit  = in_fire && !start_mul;
      res_d.bad_index = bad;
    end
    for (int i = 0; i < NumRegs; i++) begin
      rf_d[i] = (wr_en && wr_idx == IdxW'(i)) ? wr_val : rf_base[i];
    end
    npc = bound ? read_reg(rf_d, ip_q) + DataWidth'(1) : pc_q + DataWidth'(1);
    res_d.next_pc       = npc;
    res_d.written_value = wr_val;
    if (!wr_en) begin
      res_d.written_value = '0;
    end
    res_d.halted = 64'(npc) >= 64'(plen_q);
  end

  assign pop = (count_q != 2'd0) && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        rf_q[i] <= '0;
      end
      pc_q     <= '0;
      ip_q     <= '0;
      plen_q   <= PlenW'(1);
      busy_q   <= 1'b0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_reg_e'(cfg_i.index))
          CfgIpBinding:     ip_q   <= cfg_i.data[IdxW-1:0];
          CfgProgramLength: plen_q <= cfg_i.data[PlenW-1:0];
          default:          ;
        endcase
      end
      busy_q <= start_mul;
      if (start_mul) begin
        rf_q <= rf_eff;
      end else if (commit) begin
        rf_q <= rf_d;
        pc_q <= npc;
      end
      if (commit) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (commit && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (!commit && pop) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_mul) begin
      mul_dest_q <= in_i.dest_reg;
      p0_q <= (2*HalfW)'(va[HalfW-1:0]) * (2*HalfW)'(vb[HalfW-1:0]);
      p1_q <= HiW'(va[HalfW-1:0] * vb[DataWidth-1:HalfW]);
      p2_q <= HiW'(va[DataWidth-1:HalfW] * vb[HalfW-1:0]);
    end
    if (commit) begin
      fifo_q[wr_ptr_q] <= res_d;
    end
  end

  assign out_o.valid         = count_q != 2'd0;
  assign out_o.next_pc       = fifo_q[rd_ptr_q].next_pc;
  assign out_o.written_value = fifo_q[rd_ptr_q].written_value;
  assign out_o.halted        = fifo_q[rd_ptr_q].halted;
  assign out_o.bad_index     = fifo_q[rd_ptr_q].bad_index;

endmodule

`default_nettype wire

FILE: bench/six_register_machine_step_tb.sv
// Self-checking testbench for the six-register machine step block.
module six_register_machine_step_tb;
  import srm_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 4;

  typedef logic [OperandW-1:0] operand_t;
  typedef logic [IdxW-1:0]     reg_idx_t;

  logic clk = 1'b0;
  logic rst_n;

  srm_cfg_if cfg_bus ();
  srm_in_if  instr_bus ();
  srm_out_if result_bus ();

  six_register_machine_step i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_bus),
    .in_i  (instr_bus),
    .out_o (result_bus)
  );

  // Shadow copy of the machine state and configuration.
  word_t             shadow_regs [NumRegs];
  word_t             shadow_pc;
  reg_idx_t          ip_bind;
  logic [PlenW-1:0]  prog_len;

  result_t predicted_results [$];

  int src_idle_pct  = 30;
  int sink_idle_pct = 50;
  int mismatches    = 0;
  int n_instrs      = 0;
  int n_cfg_writes  = 0;
  int n_checked     = 0;

  initial begin
    for (int i = 0; i < NumRegs; i++) begin
      shadow_regs[i] = '0;
    end
    shadow_pc = '0;
    ip_bind   = '0;
    prog_len  = PlenW'(1);
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic result_t execute_instr(op_e op, operand_t a, operand_t b, reg_idx_t d);
    logic    a_is_reg, b_is_reg, bad, bound;
    word_t   va, vb, val, npc;
    result_t r;
    bound = ip_bind < NumRegs;
    if (bound) begin
      shadow_regs[ip_bind] = shadow_pc;
    end
    case (op)
      OpAddr, OpMulr, OpBanr, OpBorr, OpGtrr, OpEqrr: begin
        a_is_reg = 1'b1;
        b_is_reg = 1'b1;
      end
      OpAddi, OpMuli, OpBani, OpBori, OpSetr, OpGtri, OpEqri: begin
        a_is_reg = 1'b1;
        b_is_reg = 1'b0;
      end
      OpGtir, OpEqir: begin
        a_is_reg = 1'b0;
        b_is_reg = 1'b1;
      end
      default: begin
        a_is_reg = 1'b0;
        b_is_reg = 1'b0;
      end
    endcase
    bad = 1'b0;
    va  = '0;
    vb  = '0;
    val = '0;
    if (!a_is_reg) begin
      va = word_t'(a);
    end else if (a >= NumRegs) begin
      bad = 1'b1;
    end else begin
      va = shadow_regs[a[IdxW-1:0]];
    end
    if (!b_is_reg) begin
      vb = word_t'(b);
    end else if (b >= NumRegs) begin
      bad = 1'b1;
    end else begin
      vb = shadow_regs[b[IdxW-1:0]];
    end
    if (d >= NumRegs) begin
      bad = 1'b1;
    end
    if (!bad) begin
      case (op)
        OpAddr, OpAddi:         val = va + vb;
        OpMulr, OpMuli:         val = va * vb;
        OpBanr, OpBani:         val = va & vb;
        OpBorr, OpBori:         val = va | vb;
        OpSetr, OpSeti:         val = va;
        OpGtir, OpGtri, OpGtrr: val = word_t'(va > vb);
        default:                val = word_t'(va == vb);
      endcase
      shadow_regs[d] = val;
    end
    npc = bound ? shadow_regs[ip_bind] + 1 : shadow_pc + 1;
    shadow_pc = npc;
    r.next_pc       = npc;
    r.written_value = val;
    r.halted        = npc >= word_t'(prog_len);
    r.bad_index     = bad;
    return r;
  endfunction

  function automatic operand_t rand_operand();
    int pick;
    pick = $urandom_range(0, 23);
    if (pick < 20) begin
      return $urandom_range(0, NumRegs - 1);
    end
    if (pick == 20) begin
      return $urandom_range(NumRegs, 7);
    end
    if (pick == 21) begin
      return '1;
    end
    return $urandom;
  endfunction

  function automatic reg_idx_t rand_dest();
    if ($urandom_range(0, 15) < 14) begin
      return reg_idx_t'($urandom_range(0, NumRegs - 1));
    end
    return reg_idx_t'($urandom_range(NumRegs, 7));
  endfunction

  task automatic send_instr(op_e op, operand_t a, operand_t b, reg_idx_t d);
    result_t expected;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      instr_bus.valid <= 1'b0;
      @(posedge clk);
    end
    instr_bus.valid     <= 1'b1;
    instr_bus.mode      <= op;
    instr_bus.operand_a <= a;
    instr_bus.operand_b <= b;
    instr_bus.dest_reg  <= d;
    do @(posedge clk); while (!instr_bus.ready);
    expected = execute_instr(op, a, b, d);
    predicted_results = {predicted_results, expected};
    n_instrs++;
  endtask

  task automatic wait_idle();
    instr_bus.valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_reg_e idx, logic [CfgDataW-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    if (idx == CfgIpBinding) begin
      ip_bind = data[IdxW-1:0];
    end else begin
      prog_len = data[PlenW-1:0];
    end
    n_cfg_writes++;
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_config();
    reg_idx_t         ip;
    logic [PlenW-1:0] len;
    ip = ($urandom_range(0, 9) < 8) ? reg_idx_t'($urandom_range(0, 7))
                                    : reg_idx_t'($urandom_range(0, NumRegs - 1));
    case ($urandom_range(0, 4))
      0:       len = '0;
      1:       len = '1;
      2:       len = PlenW'(1);
      3:       len = PlenW'($urandom_range(2, 400));
      default: len = PlenW'($urandom);
    endcase
    cfg_write(CfgIpBinding, {13'($urandom), ip});
    cfg_write(CfgProgramLength, len);
  endtask

  task automatic test_reset_defaults();
    send_instr(OpAddr, 0, 0, 0);
  endtask

  task automatic test_all_opcodes();
    wait_idle();
    cfg_write(CfgIpBinding, 16'd5);
    cfg_write(CfgProgramLength, 16'hFFFF);
    send_instr(OpSeti, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    send_instr(OpAddi, 1, 2, 2);
    send_instr(OpMulr, 1, 2, 3);
    send_instr(OpAddr, 3, 3, 4);
    send_instr(OpMuli, 3, 32'hFFFF_FFFF, 4);
    send_instr(OpBanr, 3, 2, 0);
    send_instr(OpBani, 3, 32'h0F0F_0F0F, 0);
    send_instr(OpBorr, 1, 2, 4);
    send_instr(OpBori, 0, 32'hFFFF_FFFF, 4);
    send_instr(OpSetr, 3, 32'hFFFF_FFFF, 1);
    send_instr(OpGtir, 32'hFFFF_FFFF, 3, 0);
    send_instr(OpGtri, 3, 32'hFFFF_FFFF, 0);
    send_instr(OpGtrr, 2, 1, 0);
    send_instr(OpEqir, 0, 0, 2);
    send_instr(OpEqri, 2, 1, 4);
    send_instr(OpEqrr, 3, 1, 0);
  endtask

  task automatic test_bad_index();
    send_instr(OpAddr, 6, 0, 1);
    send_instr(OpMulr, 0, 32'hFFFF_FFFF, 1);
    send_instr(OpSeti, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7);
    send_instr(OpEqir, 32'hFFFF_FFFF, 7, 2);
  endtask

  task automatic test_pc_wrap();
    wait_idle();
    cfg_write(CfgIpBinding, 16'd1);
    cfg_write(CfgProgramLength, 16'd0);
    send_instr(OpSeti, 32'hFFFF_FFFF, 0, 2);
    send_instr(OpAddi, 2, 2, 3);
    send_instr(OpMulr, 2, 3, 1);
  endtask

  task automatic test_unbound_pointer();
    wait_idle();
    cfg_write(CfgIpBinding, 16'hFFFE);
    send_instr(OpAddr, 0, 1, 2);
    wait_idle();
    cfg_write(CfgIpBinding, 16'h0007);
    send_instr(OpGtrr, 1, 2, 3);
  endtask

  task automatic test_random_traffic(int n_items, int src_pct, int sink_pct);
    int until_reconfig;
    src_idle_pct   = src_pct;
    sink_idle_pct  = sink_pct;
    until_reconfig = 0;
    for (int i = 0; i < n_items; i++) begin
      if (until_reconfig == 0) begin
        wait_idle();
        random_config();
        until_reconfig = $urandom_range(20, 80);
      end
      until_reconfig--;
      send_instr(op_e'($urandom_range(0, 15)), rand_operand(), rand_operand(), rand_dest());
    end
  endtask

  always @(posedge clk) begin
    result_bus.ready <= $urandom_range(0, 99) >= sink_idle_pct;
  end

  function automatic void compare_field(string name, word_t want, word_t got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst_n && result_bus.valid && result_bus.ready) begin
      if (predicted_results.size() == 0) begin
        $display("%0t: result with no instruction pending, actual next_pc %h value %h",
                 $time, result_bus.next_pc, result_bus.written_value);
        mismatches++;
      end else begin
        want = predicted_results.pop_front();
        n_checked++;
        compare_field("next_pc", want.next_pc, result_bus.next_pc);
        compare_field("written_value", want.written_value, result_bus.written_value);
        compare_field("halted", word_t'(want.halted), word_t'(result_bus.halted));
        compare_field("bad_index", word_t'(want.bad_index), word_t'(result_bus.bad_index));
      end
    end
  end

  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((instr_bus.valid && instr_bus.ready) || (result_bus.valid && result_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("%0t: no transaction for %0d cycles, %0d results outstanding",
             $time, WatchdogLimit, predicted_results.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_n               <= 1'b0;
    instr_bus.valid     <= 1'b0;
    instr_bus.mode      <= OpAddr;
    instr_bus.operand_a <= '0;
    instr_bus.operand_b <= '0;
    instr_bus.dest_reg  <= '0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= CfgIpBinding;
    cfg_bus.data        <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_all_opcodes();
    test_bad_index();
    test_pc_wrap();
    test_unbound_pointer();
    test_random_traffic(280, 30, 50);
    test_random_traffic(280, 50, 30);
    test_random_traffic(280, 0, 0);
    wait_idle();

    $display("Executed %0d instructions under %0d configuration writes, with directed",
             n_instrs, n_cfg_writes);
    $display("opcode, bad index, pc wrap and unbound pointer cases; %0d results checked.",
             n_checked);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/srm_pkg.sv
rtl/srm_in_if.sv
rtl/srm_out_if.sv
rtl/srm_cfg_if.sv
rtl/six_register_machine_step.sv
bench/six_register_machine_step_tb.sv
